@@ design/assert_macros.svh @@
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising clk edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tvs_pkg.sv @@
`timescale 1ns / 1ps
package tvs_pkg;
  localparam int VOL_W = 64;
  localparam int VOL_H = 64;
  localparam int VOL_D = 64;
  localparam int VOL_MAX_WH = (VOL_W > VOL_H) ? VOL_W : VOL_H;
  localparam int VOL_MAX = (VOL_MAX_WH > VOL_D) ? VOL_MAX_WH : VOL_D;
  localparam int CELL_W = $clog2(VOL_MAX);
  localparam int STORE_AW = 18;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int VAL_W = 16;
  localparam int WGT_W = 17;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;

  localparam logic [CFG_IW-1:0] CFG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BOX_MIN_X = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_BOX_MIN_Y = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BOX_MIN_Z = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_VPU_X = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_VPU_Y = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_VPU_Z = 3'd6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam logic MODE_TRILINEAR = 1'b0;
  localparam logic MODE_NEAREST = 1'b1;

  localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;
  localparam logic [15:0] BOX_MIN_RST = 16'hF000;
  localparam logic [16:0] VPU_RST = 17'd8192;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [WGT_W-1:0] wgt_t;
  typedef logic [VAL_W-1:0] val_t;

  function automatic val_t lerp16(val_t a, val_t b, wgt_t w);
    logic signed [16:0] diff;
    logic signed [35:0] prod;
    logic signed [35:0] s;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = 36'(diff * $signed({1'b0, w}));
    s = $signed({4'b0, a, 16'b0}) + prod + 36'sd32768;
    return s[31:16];
  endfunction
endpackage

@@ design/tvs_ram.sv @@
`timescale 1ns / 1ps
module tvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ design/tvs_axis.sv @@
`timescale 1ns / 1ps
module tvs_axis (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  pos,
  input  logic signed [15:0]  bmin,
  input  logic [16:0]         vpu,
  input  tvs_pkg::cell_t      dim_m2,
  output tvs_pkg::cell_t      cell_idx,
  output tvs_pkg::wgt_t       weight
);
  logic signed [16:0] rel_r;
  logic signed [34:0] u_r;
  tvs_pkg::cell_t     cell_r, cell_nxt;
  tvs_pkg::wgt_t      weight_r, weight_nxt;
  logic [14:0]        c;

  always_comb begin
    c = u_r[34:20];
    if (u_r[34]) begin
      cell_nxt = '0;
      weight_nxt = '0;
    end else if (c > 15'(dim_m2)) begin
      cell_nxt = dim_m2;
      weight_nxt = tvs_pkg::WGT_ONE;
    end else begin
      cell_nxt = c[tvs_pkg::CELL_W-1:0];
      weight_nxt = {1'b0, u_r[19:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel_r <= 17'(pos) - 17'(bmin);
      u_r <= 35'(rel_r * $signed({1'b0, vpu}));
      cell_r <= cell_nxt;
      weight_r <= weight_nxt;
    end
  end

  assign cell_idx = cell_r;
  assign weight = weight_r;
endmodule

@@ design/trilinear_volume_sampler.sv @@
`timescale 1ns / 1ps
// A sample item passes through registered stages a to h, then the output register that raises out_valid.
// Throughput: one item per cycle unless out_stall holds back a pending result; a write item gives no result.
// Every stage, the eight voxel memory copies included, advances together.
// Reset (rst_n low, synchronous) clears valid bits and sets config registers to their defaults;
// voxel memory is not cleared and is undefined until written.
`include "assert_macros.svh"
module trilinear_volume_sampler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [17:0]                in_voxel_address,
  input  logic [15:0]                in_voxel_value,
  input  logic signed [15:0]         in_pos_x,
  input  logic signed [15:0]         in_pos_y,
  input  logic signed [15:0]         in_pos_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_sample_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tvs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tvs_pkg::CFG_DW-1:0] cfg_data
);
  localparam int NC = 8;
  localparam int AW = tvs_pkg::STORE_AW;

  typedef struct packed {
    logic        cmd;
    logic [17:0] addr;
    logic [15:0] value;
  } meta_t;

  logic        filter_mode_r;
  logic [15:0] box_min_x_r, box_min_y_r, box_min_z_r;
  logic [16:0] vpu_x_r, vpu_y_r, vpu_z_r;

  logic        en;
  logic        a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, h_v_r;
  meta_t       a_m_r, b_m_r, c_m_r, d_m_r;
  logic        e_smp_r, f_smp_r, g_smp_r, h_smp_r;
  logic signed [15:0] a_px_r, a_py_r, a_pz_r;

  tvs_pkg::cell_t cx, cy, cz;
  tvs_pkg::wgt_t  wx, wy, wz;
  tvs_pkg::wgt_t  e_wx_r, e_wy_r, e_wz_r, f_wx_r, f_wy_r, f_wz_r;
  tvs_pkg::wgt_t  g_wy_r, g_wz_r, h_wz_r;

  logic [AW-1:0]  e_raddr_r [NC];
  logic [AW-1:0]  e_waddr_r;
  logic [15:0]    e_wdata_r;
  logic           e_we_r;
  tvs_pkg::val_t  rd [NC];
  tvs_pkg::val_t  g_lx_r [4];
  tvs_pkg::val_t  g_near_r, h_near_r;
  tvs_pkg::val_t  h_c0_r, h_c1_r;
  tvs_pkg::val_t  out_value_r, out_value_nxt;
  logic           out_valid_r;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= tvs_pkg::MODE_TRILINEAR;
      box_min_x_r <= tvs_pkg::BOX_MIN_RST;
      box_min_y_r <= tvs_pkg::BOX_MIN_RST;
      box_min_z_r <= tvs_pkg::BOX_MIN_RST;
      vpu_x_r <= tvs_pkg::VPU_RST;
      vpu_y_r <= tvs_pkg::VPU_RST;
      vpu_z_r <= tvs_pkg::VPU_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvs_pkg::CFG_FILTER_MODE: filter_mode_r <= cfg_data[0];
        tvs_pkg::CFG_BOX_MIN_X:   box_min_x_r <= cfg_data[15:0];
        tvs_pkg::CFG_BOX_MIN_Y:   box_min_y_r <= cfg_data[15:0];
        tvs_pkg::CFG_BOX_MIN_Z:   box_min_z_r <= cfg_data[15:0];
        tvs_pkg::CFG_VPU_X:       vpu_x_r <= cfg_data;
        tvs_pkg::CFG_VPU_Y:       vpu_y_r <= cfg_data;
        tvs_pkg::CFG_VPU_Z:       vpu_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tvs_axis u_axis_x (
    .clk(clk), .en(en), .pos(a_px_r), .bmin($signed(box_min_x_r)), .vpu(vpu_x_r),
    .dim_m2(tvs_pkg::CELL_W'(tvs_pkg::VOL_W - 2)), .cell_idx(cx), .weight(wx)
  );
  tvs_axis u_axis_y (
    .clk(clk), .en(en), .pos(a_py_r), .bmin($signed(box_min_y_r)), .vpu(vpu_y_r),
    .dim_m2(tvs_pkg::CELL_W'(tvs_pkg::VOL_H - 2)), .cell_idx(cy), .weight(wy)
  );
  tvs_axis u_axis_z (
    .clk(clk), .en(en), .pos(a_pz_r), .bmin($signed(box_min_z_r)), .vpu(vpu_z_r),
    .dim_m2(tvs_pkg::CELL_W'(tvs_pkg::VOL_D - 2)), .cell_idx(cz), .weight(wz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      e_we_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
      e_we_r <= d_v_r && (d_m_r.cmd == tvs_pkg::CMD_WRITE);
      out_valid_r <= h_v_r && h_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m_r <= '{cmd: in_command, addr: in_voxel_address, value: in_voxel_value};
      a_px_r <= in_pos_x;
      a_py_r <= in_pos_y;
      a_pz_r <= in_pos_z;
      b_m_r <= a_m_r;
      c_m_r <= b_m_r;
      d_m_r <= c_m_r;
      e_smp_r <= d_m_r.cmd == tvs_pkg::CMD_SAMPLE;
      e_waddr_r <= d_m_r.addr;
      e_wdata_r <= d_m_r.value;
      e_wx_r <= wx;
      e_wy_r <= wy;
      e_wz_r <= wz;
      f_smp_r <= e_smp_r;
      f_wx_r <= e_wx_r;
      f_wy_r <= e_wy_r;
      f_wz_r <= e_wz_r;
      g_smp_r <= f_smp_r;
      g_wy_r <= f_wy_r;
      g_wz_r <= f_wz_r;
      g_near_r <= rd[0];
      h_smp_r <= g_smp_r;
      h_wz_r <= g_wz_r;
      h_near_r <= g_near_r;
      h_c0_r <= tvs_pkg::lerp16(g_lx_r[0], g_lx_r[1], g_wy_r);
      h_c1_r <= tvs_pkg::lerp16(g_lx_r[2], g_lx_r[3], g_wy_r);
      out_value_r <= out_value_nxt;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_corner
    localparam int CELL_W_P1 = tvs_pkg::CELL_W + 1;
    logic [CELL_W_P1-1:0] xi, yi, zi;
    logic [31:0]          off;
    assign xi = CELL_W_P1'(cx) + CELL_W_P1'(k & 1);
    assign yi = CELL_W_P1'(cy) + CELL_W_P1'((k >> 1) & 1);
    assign zi = CELL_W_P1'(cz) + CELL_W_P1'((k >> 2) & 1);
    assign off = 32'(xi) + 32'(tvs_pkg::VOL_W) * (32'(yi) + 32'(tvs_pkg::VOL_H) * 32'(zi));

    always_ff @(posedge clk) begin
      if (en) begin
        e_raddr_r[k] <= off[AW-1:0];
      end
    end

    tvs_ram #(.WIDTH(tvs_pkg::VAL_W), .DEPTH(tvs_pkg::STORE_DEPTH)) u_ram (
      .clk(clk), .en(en), .we(e_we_r), .waddr(e_waddr_r), .wdata(e_wdata_r),
      .raddr(e_raddr_r[k]), .rdata(rd[k])
    );
  end

  for (genvar j = 0; j < 4; j++) begin : g_lerp_x
    always_ff @(posedge clk) begin
      if (en) begin
        g_lx_r[j] <= tvs_pkg::lerp16(rd[2*j], rd[2*j+1], f_wx_r);
      end
    end
  end

  always_comb begin
    if (filter_mode_r == tvs_pkg::MODE_NEAREST) begin
      out_value_nxt = h_near_r;
    end else begin
      out_value_nxt = tvs_pkg::lerp16(h_c0_r, h_c1_r, h_wz_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_sample_value = out_value_r;

  `ASSERT_CLK(a_freeze, !en |=> $stable(h_v_r) && $stable(a_v_r), "pipeline moved while stalled")
  `ASSERT_CLK(a_write_quiet, en && h_v_r && !h_smp_r |=> !out_valid_r, "write item gave a result")
  `ASSERT_CLK(a_sample_out, en && h_v_r && h_smp_r |=> out_valid_r, "sample item lost")
  `ASSERT_CLK(a_we_write, e_we_r |-> !e_smp_r, "memory written by a sample item")
endmodule
